// ===== hw/rtl/s2a_pkg.sv =====
// Shared types, constants and key tables for the scancode-to-ASCII block.
// No dependencies; imported by every module of the block except s2a_ram.
`default_nettype none

package s2a_pkg;

  localparam int SCAN_W         = 8;
  localparam int CODE_W         = 7;
  localparam int CHAR_W         = 7;
  localparam int FILL_W         = 7;
  localparam int RING_DEPTH_DEF = 128;
  localparam int Q_DEPTH        = 2;
  localparam int REL_BIT        = 7;

  // Set-1 make codes of the two shift keys
  localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;

  // Request kinds on the input channel
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_READ = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [CHAR_W-1:0]   ch;
  } op_t;

  // US layout, unshifted printable keys; zero means no character
  function automatic logic [CHAR_W-1:0] plain_key(input logic [CODE_W-1:0] code);
    case (code)
      7'h02: return 7'h31;  7'h03: return 7'h32;  7'h04: return 7'h33;
      7'h05: return 7'h34;  7'h06: return 7'h35;  7'h07: return 7'h36;
      7'h08: return 7'h37;  7'h09: return 7'h38;  7'h0A: return 7'h39;
      7'h0B: return 7'h30;  7'h0C: return 7'h2D;  7'h0D: return 7'h3D;
      7'h0E: return 7'h08;  7'h0F: return 7'h09;
      7'h10: return 7'h71;  7'h11: return 7'h77;  7'h12: return 7'h65;
      7'h13: return 7'h72;  7'h14: return 7'h74;  7'h15: return 7'h79;
      7'h16: return 7'h75;  7'h17: return 7'h69;  7'h18: return 7'h6F;
      7'h19: return 7'h70;  7'h1A: return 7'h5B;  7'h1B: return 7'h5D;
      7'h1C: return 7'h0A;
      7'h1E: return 7'h61;  7'h1F: return 7'h73;  7'h20: return 7'h64;
      7'h21: return 7'h66;  7'h22: return 7'h67;  7'h23: return 7'h68;
      7'h24: return 7'h6A;  7'h25: return 7'h6B;  7'h26: return 7'h6C;
      7'h27: return 7'h3B;  7'h28: return 7'h27;  7'h29: return 7'h60;
      7'h2B: return 7'h5C;
      7'h2C: return 7'h7A;  7'h2D: return 7'h78;  7'h2E: return 7'h63;
      7'h2F: return 7'h76;  7'h30: return 7'h62;  7'h31: return 7'h6E;
      7'h32: return 7'h6D;  7'h33: return 7'h2C;  7'h34: return 7'h2E;
      7'h35: return 7'h2F;
      7'h39: return 7'h20;
      default: return '0;
    endcase
  endfunction

  // US layout, shifted printable keys
  function automatic logic [CHAR_W-1:0] upper_key(input logic [CODE_W-1:0] code);
    case (code)
      7'h02: return 7'h21;  7'h03: return 7'h40;  7'h04: return 7'h23;
      7'h05: return 7'h24;  7'h06: return 7'h25;  7'h07: return 7'h5E;
      7'h08: return 7'h26;  7'h09: return 7'h2A;  7'h0A: return 7'h28;
      7'h0B: return 7'h29;  7'h0C: return 7'h5F;  7'h0D: return 7'h2B;
      7'h0E: return 7'h08;  7'h0F: return 7'h09;
      7'h10: return 7'h51;  7'h11: return 7'h57;  7'h12: return 7'h45;
      7'h13: return 7'h52;  7'h14: return 7'h54;  7'h15: return 7'h59;
      7'h16: return 7'h55;  7'h17: return 7'h49;  7'h18: return 7'h4F;
      7'h19: return 7'h50;  7'h1A: return 7'h7B;  7'h1B: return 7'h7D;
      7'h1C: return 7'h0A;
      7'h1E: return 7'h41;  7'h1F: return 7'h53;  7'h20: return 7'h44;
      7'h21: return 7'h46;  7'h22: return 7'h47;  7'h23: return 7'h48;
      7'h24: return 7'h4A;  7'h25: return 7'h4B;  7'h26: return 7'h4C;
      7'h27: return 7'h3A;  7'h28: return 7'h22;  7'h29: return 7'h7E;
      7'h2B: return 7'h7C;
      7'h2C: return 7'h5A;  7'h2D: return 7'h58;  7'h2E: return 7'h43;
      7'h2F: return 7'h56;  7'h30: return 7'h42;  7'h31: return 7'h4E;
      7'h32: return 7'h4D;  7'h33: return 7'h3C;  7'h34: return 7'h3E;
      7'h35: return 7'h3F;
      7'h39: return 7'h20;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/s2a_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module s2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s2a_front.sv =====
// Front end: accepts input transactions, tracks shift and maps key presses.
// Depends on s2a_pkg (key tables, op_t).
`default_nettype none

module s2a_front
  import s2a_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req,
  input  wire logic [SCAN_W-1:0] in_scan,
  output logic                   q_push,
  output op_t                    q_data,
  input  wire logic              q_ready
);

  logic              shift_r, shift_nxt;
  logic [CODE_W-1:0] code;
  logic [CHAR_W-1:0] lookup;
  logic              accept;

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;
  assign q_push   = accept;
  assign code     = in_scan[CODE_W-1:0];
  assign lookup   = shift_r ? upper_key(code) : plain_key(code);

  // classify the incoming transaction
  always_comb begin
    q_data    = '{kind: OP_NONE, ch: '0};
    shift_nxt = shift_r;
    if (in_req == REQ_READ) begin
      q_data.kind = OP_READ;
    end else if (in_scan[REL_BIT]) begin
      if (code inside {KEY_LSHIFT, KEY_RSHIFT}) begin
        shift_nxt = 1'b0;
      end
    end else if (code inside {KEY_LSHIFT, KEY_RSHIFT}) begin
      shift_nxt = 1'b1;
    end else if (lookup != '0) begin
      q_data.kind = OP_PUSH;
      q_data.ch   = lookup;
    end
  end

  // shift state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s2a_queue.sv =====
// Short FIFO of decoded operations between front and back end.
// Depends on s2a_pkg (op_t, Q_DEPTH).
`default_nettype none

module s2a_queue
  import s2a_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_data,
  output logic      push_ready,
  input  wire logic pop,
  output logic      pop_valid,
  output op_t       pop_data
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = QAW + 1;

  op_t            entry_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != QCW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s2a_back.sv =====
// Back end: character ring pointers, ring RAM and the result register.
// Depends on s2a_pkg and s2a_ram.
`default_nettype none

module s2a_back
  import s2a_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire op_t               q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_char_valid,
  output logic                   out_dropped,
  output logic [FILL_W-1:0]      out_fill
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (AW + 1 > FILL_W) ? AW + 1 : FILL_W;

  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic              empty, full, adv;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CW-1:0]     count;
  logic              res_vld_r, cv_r, drop_r, cv_nxt, drop_nxt;
  logic [FILL_W-1:0] fill_r;

  assign wp_inc = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == AW'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign empty  = (wp_r == rp_r);
  assign full   = (wp_inc == rp_r);

  // execute one operation whenever the result register can take it
  assign adv   = q_valid & (~res_vld_r | out_ready);
  assign q_pop = adv;

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    cv_nxt   = 1'b0;
    drop_nxt = 1'b0;
    if (adv) begin
      case (q_data.kind)
        OP_PUSH: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            ram_we = 1'b1;
            wp_nxt = wp_inc;
          end
        end
        OP_READ: begin
          if (!empty) begin
            ram_re = 1'b1;
            cv_nxt = 1'b1;
            rp_nxt = rp_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ring occupancy after this operation
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      count = CW'(wp_nxt) - CW'(rp_nxt);
    end else begin
      count = CW'(wp_nxt) + CW'(RING_DEPTH) - CW'(rp_nxt);
    end
  end

  s2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (q_data.ch),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // result register; RAM read data lines up with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cv_r   <= cv_nxt;
      drop_r <= drop_nxt;
      fill_r <= count[FILL_W-1:0];
    end
  end

  assign out_valid      = res_vld_r;
  assign out_char       = cv_r ? ram_rdata : '0;
  assign out_char_valid = cv_r;
  assign out_dropped    = drop_r;
  assign out_fill       = fill_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_to_ascii_fifo.sv =====
// Set-1 scancode to ASCII converter with a character ring buffer.
// Throughput: one transaction per cycle sustained, in either direction, while out_tready is high.
// Path: an accepted transaction is written into the queue register, then into the
// result register, which raises out_tvalid; the ring RAM's registered read lines up.
// Reset (synchronous, rst_n low): shift flag, ring pointers, queue pointers and result
// valid flag clear at once; ring, queue and result data stay, no clearing pass.
`default_nettype none

module scancode_to_ascii_fifo
  import s2a_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] scan_byte
  input  wire logic [0:0]  in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [6:0] char_out, [7] char_valid,
                                       // [8] key_dropped, [15:9] fill_level
);

  logic              q_push, q_ready, q_valid, q_pop;
  op_t               q_in, q_out;
  logic [CHAR_W-1:0] r_char;
  logic              r_cv, r_drop;
  logic [FILL_W-1:0] r_fill;

  s2a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_tuser[0]),
    .in_scan  (in_tdata),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_ready  (q_ready)
  );

  s2a_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  s2a_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_char       (r_char),
    .out_char_valid (r_cv),
    .out_dropped    (r_drop),
    .out_fill       (r_fill)
  );

  // pack result transaction
  assign out_tdata = {r_fill, r_drop, r_cv, r_char};

endmodule

`default_nettype wire
